/* rtl/ssmm_pkg.sv */
// shared types and constants for the slot select and memory mapper
`timescale 1ns / 1ps
`default_nettype none

package ssmm_pkg;

	// access kinds
	typedef enum logic [1:0] {
		OP_MEM_RD = 2'd0,
		OP_MEM_WR = 2'd1,
		OP_IO_RD  = 2'd2,
		OP_IO_WR  = 2'd3
	} op_t;

	// device that serves an access
	typedef enum logic [3:0] {
		TGT_OPEN    = 4'd0,
		TGT_BIOS    = 4'd1,
		TGT_LOGO    = 4'd2,
		TGT_CART1   = 4'd3,
		TGT_CART2   = 4'd4,
		TGT_SUBROM  = 4'd5,
		TGT_DISKROM = 4'd6,
		TGT_RAM     = 4'd7,
		TGT_REG     = 4'd8
	} target_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_EXPANDED_SLOT3  = 3'd0,
		CFG_MAPPER_BY_MODEL = 3'd1,
		CFG_RAM_KILOBYTES   = 3'd2,
		CFG_BIOS_PRESENT    = 3'd3,
		CFG_LOGO_PRESENT    = 3'd4,
		CFG_SUBROM_PRESENT  = 3'd5,
		CFG_DISKROM_PRESENT = 3'd6
	} cfg_index_t;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 13;
	localparam int OffsetWidth   = 22;

	localparam logic [12:0] RAM_KB_RESET  = 13'd64;
	localparam logic [7:0]  PORT_PRIMARY  = 8'hA8;
	localparam logic [7:0]  PORT_MAPPER   = 8'hFC;
	localparam logic [15:0] ADDR_SECONDARY = 16'hFFFF;
	localparam logic [7:0]  OPEN_BUS_DATA = 8'hFF;

	// derived machine configuration seen by the decoder
	typedef struct packed {
		logic        expanded_slot3;
		logic        has_mapper;
		logic [7:0]  seg_mask;
		logic [16:0] plain_ram_start;   // lowest address of plain ram
		logic        bios_present;
		logic        logo_present;
		logic        subrom_present;
		logic        diskrom_present;
	} cfg_t;

	// one decoded result
	typedef struct packed {
		target_t                  target;
		logic [OffsetWidth-1:0]   phys_offset;
		logic                     write_enable;
		logic [7:0]               read_data;
	} result_t;

	// register updates caused by one access
	typedef struct packed {
		logic       wr_primary;
		logic       wr_secondary;
		logic       wr_segment;
		logic [1:0] seg_index;
		logic [7:0] value;
	} reg_update_t;

	// two-bit slot field of a select register for a 16 KB page
	function automatic logic [1:0] slot_of(input logic [7:0] sel, input logic [1:0] page);
		logic [1:0] s;
		case (page)
			2'd0:    s = sel[1:0];
			2'd1:    s = sel[3:2];
			2'd2:    s = sel[5:4];
			default: s = sel[7:6];
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/ssmm_cfg.sv */
// configuration registers and values derived from them
`timescale 1ns / 1ps
`default_nettype none

module ssmm_cfg #(
	parameter int MAX_RAM_KB = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ssmm_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [ssmm_pkg::CfgDataWidth-1:0]  cfg_data,
	output ssmm_pkg::cfg_t                          cfg
);
	import ssmm_pkg::*;

	logic        expanded_q;
	logic        mapper_model_q;
	logic [12:0] ram_kb_q;
	logic        bios_q;
	logic        logo_q;
	logic        subrom_q;
	logic        diskrom_q;

	logic [12:0] eff_kb;
	logic [8:0]  segs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expanded_q     <= 1'b0;
			mapper_model_q <= 1'b0;
			ram_kb_q       <= RAM_KB_RESET;
			bios_q         <= 1'b0;
			logo_q         <= 1'b0;
			subrom_q       <= 1'b0;
			diskrom_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPANDED_SLOT3:  expanded_q     <= cfg_data[0];
				CFG_MAPPER_BY_MODEL: mapper_model_q <= cfg_data[0];
				CFG_RAM_KILOBYTES:   ram_kb_q       <= cfg_data;
				CFG_BIOS_PRESENT:    bios_q         <= cfg_data[0];
				CFG_LOGO_PRESENT:    logo_q         <= cfg_data[0];
				CFG_SUBROM_PRESENT:  subrom_q       <= cfg_data[0];
				CFG_DISKROM_PRESENT: diskrom_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ram size clamped to what the board can hold
	assign eff_kb = (ram_kb_q > 13'(MAX_RAM_KB)) ? 13'(MAX_RAM_KB) : ram_kb_q;
	assign segs   = eff_kb[12:4];

	always_comb begin
		cfg.expanded_slot3  = expanded_q;
		cfg.has_mapper      = mapper_model_q || (ram_kb_q > 13'd64);
		cfg.seg_mask        = (segs == 9'd0) ? 8'd0 : 8'(segs - 9'd1);
		cfg.plain_ram_start = (eff_kb >= 13'd64) ? 17'd0
		                    : 17'h10000 - {1'b0, eff_kb[5:0], 10'd0};
		cfg.bios_present    = bios_q;
		cfg.logo_present    = logo_q;
		cfg.subrom_present  = subrom_q;
		cfg.diskrom_present = diskrom_q;
	end

endmodule

`default_nettype wire

/* rtl/ssmm_decode.sv */
// access decoder: slot map, mapper translation and register access
`timescale 1ns / 1ps
`default_nettype none

module ssmm_decode #(
	parameter int BIOS_BYTES = 32768
) (
	input  wire ssmm_pkg::op_t   op,
	input  wire logic [15:0]     address,
	input  wire logic [7:0]      write_data,
	input  wire ssmm_pkg::cfg_t  cfg,
	input  wire logic [7:0]      primary_sel,
	input  wire logic [7:0]      secondary_sel,
	input  wire logic [7:0]      seg_value,   // segment register at seg_index
	output logic [1:0]           seg_index,
	output ssmm_pkg::result_t    result,
	output ssmm_pkg::reg_update_t upd
);
	import ssmm_pkg::*;

	logic       is_io;
	logic       wr;
	logic [1:0] page;
	logic [1:0] prim;
	logic [1:0] sub;
	logic       exp3;
	logic [7:0] port;
	logic [OffsetWidth-1:0] mapped_off;

	assign is_io = (op == OP_IO_RD) || (op == OP_IO_WR);
	assign wr    = (op == OP_MEM_WR) || (op == OP_IO_WR);
	assign page  = address[15:14];
	assign port  = address[7:0];
	assign prim  = slot_of(primary_sel, page);
	assign sub   = slot_of(secondary_sel, page);
	assign exp3  = cfg.expanded_slot3 && (prim == 2'd3);

	// one segment register read: the page on memory, the port on io
	assign seg_index  = is_io ? port[1:0] : page;
	assign mapped_off = {seg_value & cfg.seg_mask, address[13:0]};

	always_comb begin
		result.target       = TGT_OPEN;
		result.phys_offset  = '0;
		result.write_enable = 1'b0;
		result.read_data    = OPEN_BUS_DATA;
		upd.wr_primary      = 1'b0;
		upd.wr_secondary    = 1'b0;
		upd.wr_segment      = 1'b0;
		upd.seg_index       = port[1:0];
		upd.value           = write_data;

		if (!is_io) begin
			if (address == ADDR_SECONDARY && exp3) begin
				result.target      = TGT_REG;
				result.phys_offset = OffsetWidth'(address);
				if (wr) begin
					result.write_enable = 1'b1;
					result.read_data    = 8'd0;
					upd.wr_secondary    = 1'b1;
				end else begin
					result.read_data = ~secondary_sel;
				end
			end else begin
				case (prim)
					2'd0: begin
						if (!wr && ({1'b0, address} < 17'(BIOS_BYTES)) && cfg.bios_present) begin
							result.target      = TGT_BIOS;
							result.phys_offset = OffsetWidth'(address);
							result.read_data   = 8'd0;
						end else if (!wr && page == 2'd2 && cfg.logo_present) begin
							result.target      = TGT_LOGO;
							result.phys_offset = OffsetWidth'(address[13:0]);
							result.read_data   = 8'd0;
						end
					end
					2'd1: begin
						result.target       = TGT_CART1;
						result.phys_offset  = OffsetWidth'(address);
						result.write_enable = wr;
						result.read_data    = 8'd0;
					end
					2'd2: begin
						result.target       = TGT_CART2;
						result.phys_offset  = OffsetWidth'(address);
						result.write_enable = wr;
						result.read_data    = 8'd0;
					end
					default: begin
						if (!exp3) begin
							if (cfg.has_mapper) begin
								result.target       = TGT_RAM;
								result.phys_offset  = mapped_off;
								result.write_enable = wr;
								result.read_data    = 8'd0;
							end else if ({1'b0, address} >= cfg.plain_ram_start) begin
								result.target       = TGT_RAM;
								result.phys_offset  = OffsetWidth'(address);
								result.write_enable = wr;
								result.read_data    = 8'd0;
							end
						end else if (sub == 2'd0 && !wr && cfg.subrom_present) begin
							result.target      = TGT_SUBROM;
							result.phys_offset = OffsetWidth'(address[13:0]);
							result.read_data   = 8'd0;
						end else if (sub == 2'd2 && cfg.has_mapper) begin
							result.target       = TGT_RAM;
							result.phys_offset  = mapped_off;
							result.write_enable = wr;
							result.read_data    = 8'd0;
						end else if (sub == 2'd3 && !wr && cfg.diskrom_present
						             && page == 2'd1) begin
							result.target      = TGT_DISKROM;
							result.phys_offset = OffsetWidth'(address[13:0]);
							result.read_data   = 8'd0;
						end
					end
				endcase
			end
		end else begin
			if (port == PORT_PRIMARY) begin
				result.target      = TGT_REG;
				result.phys_offset = OffsetWidth'(port);
				if (wr) begin
					result.write_enable = 1'b1;
					result.read_data    = 8'd0;
					upd.wr_primary      = 1'b1;
				end else begin
					result.read_data = primary_sel;
				end
			end else if (port >= PORT_MAPPER && cfg.has_mapper) begin
				result.target      = TGT_REG;
				result.phys_offset = OffsetWidth'(port);
				if (wr) begin
					result.write_enable = 1'b1;
					result.read_data    = 8'd0;
					upd.wr_segment      = 1'b1;
					upd.value           = write_data & cfg.seg_mask;
				end else begin
					result.read_data = seg_value | ~cfg.seg_mask;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/slot_select_memory_mapper.sv */
// top level: slot select and memory mapper access decoder
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  width  contents (low bit up)
// s_*       in   32     op[1:0], address[17:2], write_data[25:18], zero fill
// m_*       out  40     target[3:0], phys_offset[25:4], write_enable[26],
//                       read_data[34:27], zero fill
// cfg_*     in   3+13   register write, index selects the register
//
// one access per cycle sustained while m_tready stays high; each access passes through
// the input register, then the result register, before its m transfer
// slot, secondary and segment registers change when their access is decoded,
// so the next access already sees the new value
// reset clears all slot and segment registers and config flags; ram size resets to 64 KB
// a stalled m side holds the result; s_tready drops only when both stages are full

module slot_select_memory_mapper #(
	parameter int BIOS_BYTES = 32768,
	parameter int MAX_RAM_KB = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input access stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // op, address, write_data
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // target, phys_offset, write_enable, read_data
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [ssmm_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [ssmm_pkg::CfgDataWidth-1:0]  cfg_data
);
	import ssmm_pkg::*;

	// input register
	logic        valid_s1;
	op_t         op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// result register
	logic    valid_s2;
	result_t result_s2;

	// machine state
	logic [7:0] primary_q;
	logic [7:0] secondary_q;
	logic [7:0] segment_q [4];

	cfg_t        cfg;
	result_t     result;
	reg_update_t upd;
	logic [1:0]  seg_index;
	logic        advance;

	// stage 1 moves into the result register when that one is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	ssmm_cfg #(
		.MAX_RAM_KB(MAX_RAM_KB)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssmm_decode #(
		.BIOS_BYTES(BIOS_BYTES)
	) u_decode (
		.op            (op_s1),
		.address       (addr_s1),
		.write_data    (data_s1),
		.cfg           (cfg),
		.primary_sel   (primary_q),
		.secondary_sel (secondary_q),
		.seg_value     (segment_q[seg_index]),
		.seg_index     (seg_index),
		.result        (result),
		.upd           (upd)
	);

	// input register: takes a transfer whenever it has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tdata[1:0]);
			addr_s1 <= s_tdata[17:2];
			data_s1 <= s_tdata[25:18];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// slot and mapper registers, written as their access is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q   <= 8'd0;
			secondary_q <= 8'd0;
			for (int i = 0; i < 4; i++) begin
				segment_q[i] <= 8'd0;
			end
		end else if (advance) begin
			if (upd.wr_primary) begin
				primary_q <= upd.value;
			end
			if (upd.wr_secondary) begin
				secondary_q <= upd.value;
			end
			if (upd.wr_segment) begin
				segment_q[upd.seg_index] <= upd.value;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, result_s2.read_data, result_s2.write_enable,
	                   result_s2.phys_offset, result_s2.target};

endmodule

`default_nettype wire

/* sim/tb.sv */
// testbench for the slot select and memory mapper access decoder
`timescale 1ns / 1ps

module tb;
	import ssmm_pkg::*;

	// block sizes as built into the decoder by default
	localparam int unsigned BIOS_BYTES   = 32768;
	localparam int unsigned MAX_RAM_KB   = 4096;
	// receiver hold-off that fills both pipeline stages and stalls the input
	localparam int          HOLD_CYCLES  = 300;
	// cycles without any transfer before the run is declared hung
	localparam int          STALL_LIMIT  = 4000;
	// pipeline settle margin before config writes and at the end
	localparam int          DRAIN_CYCLES = 8;

	// machine configuration as the decoder sees it after register writes
	typedef struct {
		bit        expanded;
		bit        by_model;
		bit [12:0] ram_kb;
		bit        bios;
		bit        logo;
		bit        subrom;
		bit        diskrom;
	} machine_cfg_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // op[1:0], address[17:2], write_data[25:18], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // target[3:0], phys_offset[25:4], write_enable[26], read_data[34:27]
	logic                     cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;

	// predictor copy of the configuration and of the slot and segment registers
	machine_cfg_t machine;
	logic [7:0]   prim_slots;
	logic [7:0]   sec_slots;
	logic [7:0]   segment_sel [4];

	// decoded results still owed by the block, oldest first
	result_t      decode_queue [$];
	int           mismatches;
	int           idle_cycles;

	// idling controls shared by sender, receiver and tests
	bit           sender_idles;
	bit           receiver_idles;
	bit           hold_req;

	slot_select_memory_mapper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// ram size clamped to what the machine can hold
	function automatic int unsigned effective_kb();
		return (machine.ram_kb > MAX_RAM_KB) ? MAX_RAM_KB : int'(machine.ram_kb);
	endfunction

	function automatic bit mapper_present();
		return machine.by_model || (machine.ram_kb > 13'd64);
	endfunction

	// segment count minus one, no rounding to a power of two
	function automatic logic [7:0] segment_mask();
		int unsigned segs;
		segs = effective_kb() / 16;
		return (segs == 0) ? 8'd0 : 8'(segs - 1);
	endfunction

	// 16 KB segment number on top, page offset below
	function automatic logic [OffsetWidth-1:0] mapper_offset(logic [15:0] addr);
		return {segment_sel[addr[15:14]] & segment_mask(), addr[13:0]};
	endfunction

	function automatic result_t hit(target_t tgt, int unsigned off, logic we);
		result_t r;
		r.target       = tgt;
		r.phys_offset  = OffsetWidth'(off);
		r.write_enable = we;
		r.read_data    = 8'd0;
		return r;
	endfunction

	// expected result of one access; updates the predictor registers
	function automatic result_t decode_access(op_t op, logic [15:0] addr, logic [7:0] wdata);
		result_t     r;
		logic        wr;
		logic [1:0]  page;
		logic [1:0]  prim;
		logic [1:0]  sub;
		logic        split3;
		logic [7:0]  port;
		logic [7:0]  mask;
		int unsigned plain_bytes;
		r.target       = TGT_OPEN;
		r.phys_offset  = '0;
		r.write_enable = 1'b0;
		r.read_data    = OPEN_BUS_DATA;
		wr   = (op == OP_MEM_WR) || (op == OP_IO_WR);
		mask = segment_mask();
		if (op == OP_MEM_RD || op == OP_MEM_WR) begin
			page   = addr[15:14];
			prim   = 2'(prim_slots >> {page, 1'b0});
			sub    = 2'(sec_slots >> {page, 1'b0});
			split3 = machine.expanded && (prim == 2'd3);
			if (addr == ADDR_SECONDARY && split3) begin
				// secondary register, reads back inverted
				r = hit(TGT_REG, addr, wr);
				if (wr)
					sec_slots = wdata;
				else
					r.read_data = ~sec_slots;
			end else if (prim == 2'd0) begin
				if (!wr && addr < BIOS_BYTES && machine.bios)
					r = hit(TGT_BIOS, addr, 1'b0);
				else if (!wr && addr[15:14] == 2'b10 && machine.logo)
					r = hit(TGT_LOGO, addr[13:0], 1'b0);
			end else if (prim == 2'd1) begin
				r = hit(TGT_CART1, addr, wr);
			end else if (prim == 2'd2) begin
				r = hit(TGT_CART2, addr, wr);
			end else if (!split3) begin
				// plain ram fills the top of the address space, at most 64 KB
				plain_bytes = effective_kb() * 1024;
				if (plain_bytes > 32'h10000)
					plain_bytes = 32'h10000;
				if (mapper_present())
					r = hit(TGT_RAM, mapper_offset(addr), wr);
				else if (32'(addr) >= 32'h10000 - plain_bytes)
					r = hit(TGT_RAM, addr, wr);
			end else if (sub == 2'd0 && !wr && machine.subrom) begin
				r = hit(TGT_SUBROM, addr[13:0], 1'b0);
			end else if (sub == 2'd2 && mapper_present()) begin
				r = hit(TGT_RAM, mapper_offset(addr), wr);
			end else if (sub == 2'd3 && !wr && machine.diskrom && page == 2'd1) begin
				r = hit(TGT_DISKROM, addr[13:0], 1'b0);
			end
		end else begin
			// only the low byte of the port is decoded
			port = addr[7:0];
			if (port == PORT_PRIMARY) begin
				r = hit(TGT_REG, port, wr);
				if (wr)
					prim_slots = wdata;
				else
					r.read_data = prim_slots;
			end else if (port >= PORT_MAPPER && mapper_present()) begin
				// segment bits above the mask are stored as zero, read as one
				r = hit(TGT_REG, port, wr);
				if (wr)
					segment_sel[port[1:0]] = wdata & mask;
				else
					r.read_data = segment_sel[port[1:0]] | ~mask;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// sender, receiver, checker, watchdog
	// ---------------------------------------------------------------

	// offer one access, called at a falling edge and returns at one
	task automatic send_access(op_t op, logic [15:0] addr, logic [7:0] wdata);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, wdata, addr, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// transfer taken: predict in acceptance order
		decode_queue.push_back(decode_access(op, addr, wdata));
		@(negedge clk);
	endtask

	// stop offering, wait for every owed result and let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (decode_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES / 2) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CfgDataWidth-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	// write all seven registers; junk puts random bits above one-bit flags
	task automatic apply_config(machine_cfg_t c, bit junk);
		logic [11:0] fill;
		fill = junk ? 12'($urandom) : 12'd0;
		write_reg(CFG_EXPANDED_SLOT3, {fill, c.expanded});
		write_reg(CFG_MAPPER_BY_MODEL, {~fill, c.by_model});
		write_reg(CFG_RAM_KILOBYTES, c.ram_kb);
		write_reg(CFG_BIOS_PRESENT, {fill, c.bios});
		write_reg(CFG_LOGO_PRESENT, {~fill, c.logo});
		write_reg(CFG_SUBROM_PRESENT, {fill, c.subrom});
		write_reg(CFG_DISKROM_PRESENT, {~fill, c.diskrom});
		cfg_we <= 1'b0;
		machine = c;
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				stall_left = HOLD_CYCLES - 1;
			end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (m_tvalid && m_tready) begin
			got.target       = target_t'(m_tdata[3:0]);
			got.phys_offset  = m_tdata[25:4];
			got.write_enable = m_tdata[26];
			got.read_data    = m_tdata[34:27];
			if (decode_queue.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: tgt %0d off %h we %b rd %h",
						got.target, got.phys_offset, got.write_enable, got.read_data);
				mismatches++;
			end else begin
				want = decode_queue.pop_front();
				if (got.target !== want.target || got.phys_offset !== want.phys_offset ||
					got.write_enable !== want.write_enable ||
					got.read_data !== want.read_data) begin
					if (mismatches < 10)
						$display("decode mismatch: want tgt %0d off %h we %b rd %h, got tgt %0d off %h we %b rd %h",
							want.target, want.phys_offset, want.write_enable, want.read_data,
							got.target, got.phys_offset, got.write_enable, got.read_data);
					mismatches++;
				end
			end
		end
	end

	// hang detection: cycles in a row without a transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// random traffic
	// ---------------------------------------------------------------

	// mostly memory traffic, io aimed at the slot and mapper ports
	task automatic run_random(int count, bit allow_idle);
		op_t         op;
		logic [15:0] addr;
		logic [7:0]  port;
		for (int i = 0; i < count; i++) begin
			// idling switches on and off in stretches
			if (i % 32 == 0) begin
				sender_idles   = allow_idle && ($urandom_range(0, 3) != 0);
				receiver_idles = allow_idle && ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 9) < 6) begin
				op = $urandom_range(0, 1) ? OP_MEM_WR : OP_MEM_RD;
				case ($urandom_range(0, 9))
					0: addr = ADDR_SECONDARY;
					1: addr = {2'($urandom), {14{$urandom_range(0, 1) == 1}}};
					default: addr = 16'($urandom);
				endcase
			end else begin
				op = $urandom_range(0, 1) ? OP_IO_WR : OP_IO_RD;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: port = PORT_PRIMARY;
					4, 5, 6, 7: port = PORT_MAPPER | 8'($urandom_range(0, 3));
					default: port = 8'($urandom);
				endcase
				addr = {8'($urandom), port};
			end
			send_access(op, addr, 8'($urandom));
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// registers and configuration straight out of reset, nothing written
	task automatic test_reset_values();
		send_access(OP_IO_RD, 16'h00A8, 8'h00);
		send_access(OP_IO_RD, 16'h00FF, 8'h00);
		send_access(OP_MEM_RD, 16'hC000, 8'h00);
		send_access(OP_MEM_WR, 16'h0000, 8'hFF);
	endtask

	// walk the slot map by hand: rom edges, carts, expanded slot 3, mapper
	task automatic test_directed_map();
		wait_drained();
		apply_config('{1, 0, 128, 1, 1, 1, 1}, 0);
		send_access(OP_MEM_RD, 16'h0000, 8'h00);   // bios
		send_access(OP_MEM_RD, 16'h7FFF, 8'h00);   // last bios byte
		send_access(OP_MEM_RD, 16'h8000, 8'h00);   // logo start
		send_access(OP_MEM_RD, 16'hBFFF, 8'h00);   // logo end
		send_access(OP_MEM_RD, 16'hC000, 8'h00);   // slot 0 page 3 unmapped
		send_access(OP_MEM_WR, 16'h0000, 8'hA5);   // rom write dropped
		send_access(OP_IO_WR, 16'h00A8, 8'h55);    // all pages to cart 1
		send_access(OP_IO_RD, 16'hFFA8, 8'h00);
		send_access(OP_MEM_WR, 16'h1234, 8'h3C);
		send_access(OP_IO_WR, 16'h00A8, 8'hAA);    // all pages to cart 2
		send_access(OP_MEM_RD, 16'hFFFF, 8'h00);   // not the secondary register here
		send_access(OP_IO_WR, 16'h00A8, 8'hFF);    // all pages to slot 3
		send_access(OP_MEM_WR, 16'hFFFF, 8'hEC);   // sub slots 0,3,2,3
		send_access(OP_MEM_RD, 16'hFFFF, 8'h00);   // inverted readback
		send_access(OP_MEM_RD, 16'h0000, 8'h00);   // sub-rom
		send_access(OP_MEM_RD, 16'h4000, 8'h00);   // disk rom
		send_access(OP_MEM_RD, 16'hC000, 8'h00);   // 3-3 outside page 1
		send_access(OP_IO_WR, 16'h00FE, 8'hFF);    // segment masked on store
		send_access(OP_IO_RD, 16'h12FE, 8'h00);    // high bits read as one
		send_access(OP_MEM_WR, 16'h8ABC, 8'h00);   // mapper ram
		send_access(OP_IO_RD, 16'h0098, 8'h00);    // video port, open bus
	endtask

	// fixed settings at the corners of ram size, mapper and rom presence
	task automatic test_config_extremes();
		machine_cfg_t corner [6];
		corner[0] = '{0, 0, 64, 1, 1, 0, 0};     // plain 64 KB, no mapper
		corner[1] = '{0, 0, 16, 0, 1, 1, 1};     // smallest plain ram
		corner[2] = '{1, 0, 0, 1, 1, 1, 1};      // no ram at all
		corner[3] = '{0, 1, 15, 1, 0, 0, 0};     // mapper with empty mask
		corner[4] = '{1, 1, 8191, 0, 0, 1, 0};   // clamped, all ones
		corner[5] = '{1, 1, 48, 1, 1, 1, 1};     // odd size, no rounding
		foreach (corner[k]) begin
			wait_drained();
			apply_config(corner[k], k[0]);
			run_random(130, 1);
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		wait_drained();
		apply_config('{1, 0, 5000, 1, 1, 1, 1}, 1);
		hold_req = 1'b1;
		run_random(150, 1);
	endtask

	task automatic test_random_configs();
		machine_cfg_t c;
		repeat (3) begin
			c.expanded = $urandom_range(0, 1);
			c.by_model = $urandom_range(0, 1);
			c.bios     = $urandom_range(0, 1);
			c.logo     = $urandom_range(0, 1);
			c.subrom   = $urandom_range(0, 1);
			c.diskrom  = $urandom_range(0, 1);
			case ($urandom_range(0, 4))
				0, 1, 2: c.ram_kb = 13'(16 << $urandom_range(0, 8));
				3:       c.ram_kb = 13'($urandom);
				default: c.ram_kb = 13'($urandom_range(0, 128));
			endcase
			wait_drained();
			apply_config(c, 1);
			run_random(100, 1);
		end
	endtask

	// back to back at full rate, no idling on either side
	task automatic test_full_rate();
		wait_drained();
		apply_config('{1, 1, 4096, 1, 1, 1, 1}, 0);
		run_random(120, 0);
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		hold_req       = 1'b0;
		mismatches     = 0;
		idle_cycles    = 0;
		// reset values of the decoder
		machine     = '{0, 0, 64, 0, 0, 0, 0};
		prim_slots  = 8'd0;
		sec_slots   = 8'd0;
		segment_sel = '{8'd0, 8'd0, 8'd0, 8'd0};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed_map();
		test_config_extremes();
		test_backpressure();
		test_random_configs();
		test_full_rate();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
